/* sv/pic_pkg.sv */
// pic_pkg: shared types, constants and the pattern table for the packet
// intrusion classifier. No dependencies.
package pic_pkg;

    // Default sizing, handed to the top level as parameter defaults
    localparam int PATTERN_LEN_DEF = 13;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int PATTERN_MAX     = 32;

    // Verdict queue between parser and counter stage
    localparam int QUEUE_DEPTH = 2;

    // Configuration port
    localparam int PADDR_W   = 3;
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_INSPECTED_PORT = 1'b0;
    localparam logic [15:0] INSPECTED_PORT_RESET = 16'd80;

    // Header offsets and codes
    localparam logic [15:0] POS_ETYPE_HI   = 16'd12;
    localparam logic [15:0] POS_ETYPE_LO   = 16'd13;
    localparam logic [15:0] POS_IP_IHL     = 16'd14;
    localparam logic [15:0] POS_ARP_OP_HI  = 16'd20;
    localparam logic [15:0] POS_ARP_OP_LO  = 16'd21;
    localparam logic [15:0] POS_IP_PROTO   = 16'd23;
    localparam logic [7:0]  ETH_HDR_BYTES  = 8'd14;
    localparam logic [15:0] TCP_OFS_SPORT_LO = 16'd1;
    localparam logic [15:0] TCP_OFS_DPORT_HI = 16'd2;
    localparam logic [15:0] TCP_OFS_DPORT_LO = 16'd3;
    localparam logic [15:0] TCP_OFS_DOFF   = 16'd12;
    localparam logic [15:0] TCP_OFS_FLAGS  = 16'd13;

    localparam logic [15:0] ETYPE_IPV4     = 16'h0800;
    localparam logic [15:0] ETYPE_ARP      = 16'h0806;
    localparam logic [7:0]  IP_PROTO_TCP   = 8'd6;
    localparam logic [15:0] ARP_OP_REPLY   = 16'd2;
    localparam logic [7:0]  XMAS_FLAG_MASK = 8'h29;   // FIN | PSH | URG
    localparam logic [15:0] POS_MAX        = 16'hFFFF;

    // Blacklisted host string, padded with '*'
    localparam logic [7:0] PATTERN_TABLE [PATTERN_MAX] = '{
        8'h77, 8'h77, 8'h77, 8'h2E, 8'h62, 8'h62, 8'h63, 8'h2E,
        8'h63, 8'h6F, 8'h2E, 8'h75, 8'h6B, 8'h2A, 8'h2A, 8'h2A,
        8'h2A, 8'h2A, 8'h2A, 8'h2A, 8'h2A, 8'h2A, 8'h2A, 8'h2A,
        8'h2A, 8'h2A, 8'h2A, 8'h2A, 8'h2A, 8'h2A, 8'h2A, 8'h2A
    };

    // One frame verdict
    typedef struct packed {
        logic xmas;
        logic arp_reply;
        logic blacklist;
    } verdict_t;

    // Queue status seen by the parser and the counter stage
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

/* sv/pic_if.sv */
// pic_if: valid/ready channel interfaces for frame bytes and verdicts.
// No dependencies.
interface pic_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pic_verdict_if;
    logic        valid;
    logic        ready;
    logic        xmas_seen;
    logic        arp_reply_seen;
    logic        blacklist_seen;
    logic [31:0] xmas_total;
    logic [31:0] arp_reply_total;
    logic [31:0] blacklist_total;

    modport source (output valid, output xmas_seen, output arp_reply_seen,
                    output blacklist_seen, output xmas_total, output arp_reply_total,
                    output blacklist_total, input ready);
    modport sink   (input valid, input xmas_seen, input arp_reply_seen,
                    input blacklist_seen, input xmas_total, input arp_reply_total,
                    input blacklist_total, output ready);
endinterface

/* sv/pic_front.sv */
// pic_front: byte-wise header parser and payload pattern matcher.
// Depends on pic_pkg.
module pic_front #(
    parameter int PATTERN_LEN = pic_pkg::PATTERN_LEN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    input  logic [15:0]       inspected_port,
    output logic              push,
    output pic_pkg::verdict_t verdict
);
    import pic_pkg::*;

    logic [15:0] pos_reg, pos_next;
    logic [15:0] etype_reg, etype_next;
    logic [5:0]  ihb_reg, ihb_next;
    logic [7:0]  proto_reg, proto_next;
    logic [15:0] sport_reg, sport_next;
    logic [15:0] dport_reg, dport_next;
    logic [5:0]  thb_reg, thb_next;
    logic [15:0] arp_op_reg, arp_op_next;
    logic        xmas_reg, xmas_next;
    logic        zero_seen_reg, zero_seen_next;
    logic [15:0] zero_pos_reg, zero_pos_next;
    logic        matched_reg, matched_next;
    logic [7:0]  win_reg  [PATTERN_LEN];
    logic [7:0]  win_next [PATTERN_LEN];

    logic [15:0] tcp_start;
    logic [15:0] pstart;
    logic        win_eq;
    logic        search_ok;
    logic        blocked;
    logic        ip_tcp;
    logic        port_hit;

    always_comb
    begin
        etype_next  = etype_reg;
        ihb_next    = ihb_reg;
        proto_next  = proto_reg;
        arp_op_next = arp_op_reg;
        sport_next  = sport_reg;
        dport_next  = dport_reg;
        thb_next    = thb_reg;
        xmas_next   = xmas_reg;

        if (pos_reg == POS_ETYPE_HI)  etype_next[15:8]  = data_byte;
        if (pos_reg == POS_ETYPE_LO)  etype_next[7:0]   = data_byte;
        if (pos_reg == POS_IP_IHL)    ihb_next          = {data_byte[3:0], 2'b00};
        if (pos_reg == POS_ARP_OP_HI) arp_op_next[15:8] = data_byte;
        if (pos_reg == POS_ARP_OP_LO) arp_op_next[7:0]  = data_byte;
        if (pos_reg == POS_IP_PROTO)  proto_next        = data_byte;

        // TCP start follows the IHL, including one taken on this very byte
        tcp_start = {8'd0, ETH_HDR_BYTES} + {10'd0, ihb_next};
        if (pos_reg == tcp_start)                    sport_next[15:8] = data_byte;
        if (pos_reg == tcp_start + TCP_OFS_SPORT_LO) sport_next[7:0]  = data_byte;
        if (pos_reg == tcp_start + TCP_OFS_DPORT_HI) dport_next[15:8] = data_byte;
        if (pos_reg == tcp_start + TCP_OFS_DPORT_LO) dport_next[7:0]  = data_byte;
        if (pos_reg == tcp_start + TCP_OFS_DOFF)     thb_next = {data_byte[7:4], 2'b00};
        if (pos_reg == tcp_start + TCP_OFS_FLAGS)
            xmas_next = (data_byte & XMAS_FLAG_MASK) == XMAS_FLAG_MASK;

        // Window of the latest bytes, newest at the top entry
        for (int i = 0; i < PATTERN_LEN - 1; i++)
            win_next[i] = win_reg[i + 1];
        win_next[PATTERN_LEN - 1] = data_byte;

        zero_seen_next = zero_seen_reg;
        zero_pos_next  = zero_pos_reg;
        if (data_byte == 8'd0)
        begin
            zero_seen_next = 1'b1;
            zero_pos_next  = pos_reg;
        end

        win_eq = 1'b1;
        for (int i = 0; i < PATTERN_LEN; i++)
            if (win_next[i] != PATTERN_TABLE[i]) win_eq = 1'b0;

        pstart    = tcp_start + {10'd0, thb_next};
        // window start (pos + 1 - len) must not precede the payload start
        search_ok = (pos_reg >= tcp_start + TCP_OFS_DOFF) &&
                    ({1'b0, pos_reg} + 17'd1 >= {1'b0, pstart} + 17'(PATTERN_LEN));
        blocked   = zero_seen_next && (zero_pos_next >= pstart);
        matched_next = matched_reg | (search_ok && !blocked && win_eq);

        pos_next = (pos_reg != POS_MAX) ? pos_reg + 16'd1 : pos_reg;

        ip_tcp   = (etype_next == ETYPE_IPV4) && (proto_next == IP_PROTO_TCP);
        port_hit = (sport_next == inspected_port) || (dport_next == inspected_port);
        verdict.xmas      = ip_tcp && xmas_next;
        verdict.arp_reply = (etype_next == ETYPE_ARP) && (arp_op_next == ARP_OP_REPLY);
        verdict.blacklist = ip_tcp && port_hit && matched_next;
    end

    assign push = accept && last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            etype_reg     <= '0;
            ihb_reg       <= '0;
            proto_reg     <= '0;
            sport_reg     <= '0;
            dport_reg     <= '0;
            thb_reg       <= '0;
            arp_op_reg    <= '0;
            xmas_reg      <= 1'b0;
            zero_seen_reg <= 1'b0;
            zero_pos_reg  <= '0;
            matched_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                pos_reg       <= '0;
                etype_reg     <= '0;
                ihb_reg       <= '0;
                proto_reg     <= '0;
                sport_reg     <= '0;
                dport_reg     <= '0;
                thb_reg       <= '0;
                arp_op_reg    <= '0;
                xmas_reg      <= 1'b0;
                zero_seen_reg <= 1'b0;
                zero_pos_reg  <= '0;
                matched_reg   <= 1'b0;
            end
            else
            begin
                pos_reg       <= pos_next;
                etype_reg     <= etype_next;
                ihb_reg       <= ihb_next;
                proto_reg     <= proto_next;
                sport_reg     <= sport_next;
                dport_reg     <= dport_next;
                thb_reg       <= thb_next;
                arp_op_reg    <= arp_op_next;
                xmas_reg      <= xmas_next;
                zero_seen_reg <= zero_seen_next;
                zero_pos_reg  <= zero_pos_next;
                matched_reg   <= matched_next;
            end
        end
    end

    // Window bytes are only compared once a whole window lies inside the frame
    always_ff @(posedge clk)
    begin
        if (accept)
            win_reg <= win_next;
    end

endmodule

/* sv/pic_queue.sv */
// pic_queue: short verdict FIFO between parser and counter stage.
// Depends on pic_pkg.
module pic_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  pic_pkg::verdict_t    push_data,
    input  logic                 pop,
    output pic_pkg::verdict_t    head,
    output pic_pkg::queue_stat_t stat
);
    import pic_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    verdict_t          slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* sv/pic_back.sv */
// pic_back: saturating finding counters and the registered verdict output.
// Depends on pic_pkg.
module pic_back #(
    parameter int COUNT_WIDTH = pic_pkg::COUNT_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  pic_pkg::verdict_t head,
    output logic              pop,
    input  logic              out_ready,
    output logic              out_valid,
    output logic              xmas_seen,
    output logic              arp_reply_seen,
    output logic              blacklist_seen,
    output logic [31:0]       xmas_total,
    output logic [31:0]       arp_reply_total,
    output logic [31:0]       blacklist_total
);
    import pic_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic [COUNT_WIDTH-1:0] xmas_cnt_reg, xmas_cnt_next;
    logic [COUNT_WIDTH-1:0] arp_cnt_reg, arp_cnt_next;
    logic [COUNT_WIDTH-1:0] blk_cnt_reg, blk_cnt_next;
    logic                   valid_reg;
    verdict_t               flags_reg;
    logic [63:0]            xmas_ext, arp_ext, blk_ext;

    assign pop = head_valid && (!valid_reg || out_ready);

    always_comb
    begin
        xmas_cnt_next = xmas_cnt_reg;
        arp_cnt_next  = arp_cnt_reg;
        blk_cnt_next  = blk_cnt_reg;
        if (head.xmas && xmas_cnt_reg != CNT_MAX)     xmas_cnt_next = xmas_cnt_reg + 1'b1;
        if (head.arp_reply && arp_cnt_reg != CNT_MAX) arp_cnt_next  = arp_cnt_reg + 1'b1;
        if (head.blacklist && blk_cnt_reg != CNT_MAX) blk_cnt_next  = blk_cnt_reg + 1'b1;
    end

    // Counters are the output payload too: they only move on a pop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xmas_cnt_reg <= '0;
            arp_cnt_reg  <= '0;
            blk_cnt_reg  <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                xmas_cnt_reg <= xmas_cnt_next;
                arp_cnt_reg  <= arp_cnt_next;
                blk_cnt_reg  <= blk_cnt_next;
                valid_reg    <= 1'b1;
            end
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            flags_reg <= head;
    end

    assign xmas_ext = 64'(xmas_cnt_reg);
    assign arp_ext  = 64'(arp_cnt_reg);
    assign blk_ext  = 64'(blk_cnt_reg);

    assign out_valid       = valid_reg;
    assign xmas_seen       = flags_reg.xmas;
    assign arp_reply_seen  = flags_reg.arp_reply;
    assign blacklist_seen  = flags_reg.blacklist;
    assign xmas_total      = xmas_ext[31:0];
    assign arp_reply_total = arp_ext[31:0];
    assign blacklist_total = blk_ext[31:0];

endmodule

/* sv/packet_intrusion_classifier.sv */
// Packet intrusion classifier: Ethernet/IPv4/TCP/ARP frame inspector.
// Frame bytes enter on "frame" (one byte per request, last_byte closes the
// frame, starting at the destination MAC). One verdict leaves on "verdict"
// per frame, carrying the Xmas-scan, ARP-reply and blacklist flags plus the
// three saturating totals after this frame has been counted.
// Throughput: one byte per cycle, back-to-back frames too, unless the queue is full.
// The parser captures headers and compares the full pattern window in the
// same cycle the byte is accepted, so nothing in it iterates.
// The verdict is written to the verdict queue when the last byte is accepted
// and is loaded into the output register once that register is free.
// Receiver stall: verdicts wait in a two-entry queue; the parser keeps taking
// bytes until the queue is full, then frame.ready drops.
// Reset (rst_n, async, active low): parser state and totals clear,
// inspected_port returns to 80, queue and output empty. No clearing pass.
// Config: APB register 0 (byte address 0) holds inspected_port in bits 15:0;
// write it only while no frame is in flight.
// Depends on pic_pkg, pic_if, pic_front, pic_queue, pic_back.
module packet_intrusion_classifier #(
    parameter int PATTERN_LEN = pic_pkg::PATTERN_LEN_DEF,
    parameter int COUNT_WIDTH = pic_pkg::COUNT_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pic_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    pic_frame_if.sink                    frame,
    pic_verdict_if.source                verdict
);
    import pic_pkg::*;

    logic [15:0]          inspected_port_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 frame_accept;
    logic                 q_push;
    logic                 q_pop;
    verdict_t             front_verdict;
    verdict_t             q_head;
    queue_stat_t          q_stat;

    // ---- configuration port ----
    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inspected_port_reg <= INSPECTED_PORT_RESET;
        else if (psel && penable && pwrite && reg_idx == REG_INSPECTED_PORT)
            inspected_port_reg <= pwdata[15:0];
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_INSPECTED_PORT: prdata = {16'd0, inspected_port_reg};
            default:            prdata = '0;
        endcase
    end

    // ---- front: parse bytes, produce one verdict per frame ----
    // Taking bytes only depends on queue room, not on the output side.
    assign frame.ready  = !q_stat.full;
    assign frame_accept = frame.valid && frame.ready;

    pic_front #(
        .PATTERN_LEN (PATTERN_LEN)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (frame_accept),
        .data_byte      (frame.data_byte),
        .last_byte      (frame.last_byte),
        .inspected_port (inspected_port_reg),
        .push           (q_push),
        .verdict        (front_verdict)
    );

    // ---- verdict queue: decouples parser from the output handshake ----
    pic_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (front_verdict),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    // ---- back: totals and registered output ----
    pic_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (!q_stat.empty),
        .head            (q_head),
        .pop             (q_pop),
        .out_ready       (verdict.ready),
        .out_valid       (verdict.valid),
        .xmas_seen       (verdict.xmas_seen),
        .arp_reply_seen  (verdict.arp_reply_seen),
        .blacklist_seen  (verdict.blacklist_seen),
        .xmas_total      (verdict.xmas_total),
        .arp_reply_total (verdict.arp_reply_total),
        .blacklist_total (verdict.blacklist_total)
    );

`ifndef SYNTHESIS
    // A frame end never lands on a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("verdict pushed into full queue");

    // The counter stage only pops real entries
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("verdict popped from empty queue");

    // A new result is always loaded from the queue
    a_result_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(verdict.valid) |-> $past(q_pop))
        else $error("result appeared without a queue pop");

    // A verdict pushed without a pop leaves the queue non-empty
    a_queue_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !q_pop) |=> !q_stat.empty)
        else $error("pushed verdict missing from queue");
`endif

endmodule
